FILE: hw/rtl/mwr_pkg.sv
// Shared types, constants and helper functions of the modified wNAF recoder.
package mwr_pkg;

    // Scalar geometry.
    localparam int WORD_BITS         = 32;
    localparam int WORD_COUNT        = 8;
    localparam int DIGITS_PER_RESULT = 8;
    localparam int DIGIT_SLOTS       = 8;
    localparam int TOTAL_BITS        = WORD_BITS * WORD_COUNT;
    localparam int MAX_DIGITS        = TOTAL_BITS + 1;

    // Derived widths.
    localparam int WIDX_W  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int WCNT_W  = $clog2(WORD_COUNT + 1);
    localparam int LEN_W   = $clog2(TOTAL_BITS + 1);
    localparam int POS_W   = $clog2(MAX_DIGITS + 1);
    localparam int BIT_W   = $clog2(TOTAL_BITS);
    localparam int LOD_W   = $clog2(WORD_BITS);
    localparam int GIDX_W  = $clog2(DIGIT_SLOTS);
    localparam int CNT_W   = 4;
    localparam int DIGIT_W = 8;
    localparam int WIN_W   = 9;
    localparam int WW_W    = 3;
    localparam int DATA_IN_W  = 32;
    localparam int DATA_OUT_W = 72;

    localparam logic [WW_W-1:0] WW_RESET = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // store the word of the current input transfer
        logic scan_init;  // start the length scan at the top word
        logic scan_next;  // move the length scan one word down
        logic run_init;   // latch the length and the first window
        logic step;       // produce one digit
        logic emit;       // move the group into the output register
        logic emit_last;  // the emitted group closes the scalar
    } mwr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic word_nz;     // scanned word holds a set bit
        logic scan_bottom; // scan is at the lowest word
        logic more;        // another digit follows
        logic group_full;  // group buffer holds a whole group
        logic out_busy;    // output register still holds a result
    } mwr_status_t;

    // Position of the highest set bit of a word (zero for a zero word).
    function automatic logic [LOD_W-1:0] lead_one(input logic [WORD_BITS-1:0] word);
        logic [LOD_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (word[i])
            begin
                pos = LOD_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

FILE: hw/rtl/mwr_datapath.sv
// Datapath of the recoder: scalar store, length scan, digit window and output register.
module mwr_datapath
    import mwr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  window_width_wr_en,
    input  logic [WW_W-1:0]       window_width_wr_data,
    input  logic [DATA_IN_W-1:0]  s_tdata,
    input  mwr_cmd_t              cmd,
    output mwr_status_t           status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_OUT_W-1:0] m_tdata,
    output logic                  m_tlast
);

    logic [WW_W-1:0]                      window_width_reg;
    logic [WORD_COUNT-1:0][WORD_BITS-1:0] store_reg;
    logic [WCNT_W-1:0]                    word_index_reg;
    logic [WIDX_W-1:0]                    scan_idx_reg;
    logic [LEN_W-1:0]                     len_reg;
    logic [WIN_W-1:0]                     win_reg;
    logic [POS_W-1:0]                     pos_reg;
    logic [CNT_W-1:0]                     cnt_reg;
    logic [DIGIT_W-1:0]                   group_reg [DIGIT_SLOTS];
    logic [DIGIT_W-1:0]                   out_digits_reg [DIGIT_SLOTS];
    logic [CNT_W-1:0]                     out_count_reg;
    logic                                 out_last_reg;
    logic                                 out_valid_reg;

    logic [WORD_BITS-1:0] scan_word;
    logic [LEN_W-1:0]     len_next;
    logic [WW_W-1:0]      w_eff;
    logic [WIN_W-1:0]     top;
    logic [WIN_W-1:0]     win_mask;
    logic [WIN_W-1:0]     win_init;
    logic [9:0]           reach;
    logic                 near_end;
    logic [9:0]           digit;
    logic [9:0]           diff;
    logic [BIT_W-1:0]     tap;
    logic                 fetch_bit;
    logic [WIN_W-1:0]     win_next;

    // Length scan: highest set bit of the word under the scan pointer.
    assign scan_word = store_reg[scan_idx_reg];
    assign len_next  = LEN_W'(scan_idx_reg) * LEN_W'(WORD_BITS)
                     + LEN_W'(lead_one(scan_word)) + LEN_W'(1);

    // Window geometry; a width of zero acts as width one.
    assign w_eff    = (window_width_reg == '0) ? WW_W'(1) : window_width_reg;
    assign top      = WIN_W'(1) << w_eff;
    assign win_mask = (top << 1) - WIN_W'(1);
    assign win_init = WIN_W'(store_reg[0][7:0]) & win_mask;

    // Position of the bit above the window, relative to the scalar length.
    assign reach    = 10'(pos_reg) + 10'(w_eff) + 10'd1;
    assign near_end = (reach >= 10'(len_reg));

    // Digit selection: odd windows give a signed digit, the top one stays positive.
    always_comb
    begin
        digit = '0;
        if (win_reg[0])
        begin
            if ((win_reg & top) != '0)
            begin
                if (near_end)
                begin
                    digit = 10'(win_reg & (top - WIN_W'(1)));
                end
                else
                begin
                    digit = 10'(win_reg) - 10'(top << 1);
                end
            end
            else
            begin
                digit = 10'(win_reg);
            end
        end
    end

    // The store shifts down one bit per digit, so the next bit sits at w+1.
    assign tap       = BIT_W'(w_eff) + BIT_W'(1);
    assign fetch_bit = store_reg[tap[BIT_W-1:LOD_W]][tap[LOD_W-1:0]];
    assign diff      = 10'(win_reg) - digit;
    assign win_next  = diff[WIN_W:1] + (fetch_bit ? top : WIN_W'(0));

    // Status toward the controller.
    assign status.word_nz     = (scan_word != '0);
    assign status.scan_bottom = (scan_idx_reg == '0);
    assign status.more        = ((win_reg != '0) || (reach < 10'(len_reg)))
                                && (pos_reg < POS_W'(MAX_DIGITS));
    assign status.group_full  = (cnt_reg == CNT_W'(DIGITS_PER_RESULT));
    assign status.out_busy    = out_valid_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_width_reg <= WW_RESET;
            store_reg        <= '0;
            word_index_reg   <= '0;
            scan_idx_reg     <= '0;
            len_reg          <= '0;
            win_reg          <= '0;
            pos_reg          <= '0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (window_width_wr_en)
            begin
                window_width_reg <= window_width_wr_data;
            end
            if (cmd.load && (word_index_reg < WCNT_W'(WORD_COUNT)))
            begin
                store_reg[word_index_reg[WIDX_W-1:0]] <= s_tdata;
                word_index_reg <= word_index_reg + WCNT_W'(1);
            end
            if (cmd.scan_init)
            begin
                scan_idx_reg <= WIDX_W'(WORD_COUNT - 1);
            end
            if (cmd.scan_next)
            begin
                scan_idx_reg <= scan_idx_reg - WIDX_W'(1);
            end
            if (cmd.run_init)
            begin
                len_reg <= status.word_nz ? len_next : LEN_W'(0);
                win_reg <= win_init;
                pos_reg <= '0;
                cnt_reg <= '0;
            end
            if (cmd.step)
            begin
                store_reg <= store_reg >> 1;
                win_reg   <= win_next;
                pos_reg   <= pos_reg + POS_W'(1);
                cnt_reg   <= cnt_reg + CNT_W'(1);
            end
            if (cmd.emit)
            begin
                cnt_reg <= '0;
            end
            if (cmd.emit_last)
            begin
                store_reg      <= '0;
                word_index_reg <= '0;
            end
            // Output register: set on emit, cleared when the result transfers.
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: group buffer and output result.
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            group_reg[cnt_reg[GIDX_W-1:0]] <= digit[DIGIT_W-1:0];
        end
        if (cmd.emit)
        begin
            for (int s = 0; s < DIGIT_SLOTS; s++)
            begin
                out_digits_reg[s] <= (CNT_W'(s) < cnt_reg) ? group_reg[s] : '0;
            end
            out_count_reg <= cnt_reg;
            out_last_reg  <= cmd.emit_last;
        end
    end

    // Output packing: digits from the lowest bits, then the count.
    always_comb
    begin
        m_tdata = '0;
        for (int s = 0; s < DIGIT_SLOTS; s++)
        begin
            m_tdata[s*DIGIT_W +: DIGIT_W] = out_digits_reg[s];
        end
        m_tdata[DIGIT_SLOTS*DIGIT_W +: CNT_W] = out_count_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_valid_reg)
        else $error("Group emitted while the output register was occupied.");

    a_step_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (cnt_reg < CNT_W'(DIGITS_PER_RESULT)))
        else $error("Digit produced into a full group buffer.");

    a_store_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_last |=> ((store_reg == '0) && (word_index_reg == '0)))
        else $error("Scalar store not cleared after the final group.");

    a_group_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DIGITS_PER_RESULT))
        else $error("Group count beyond the group size.");
`endif

endmodule

FILE: hw/rtl/mwr_ctrl.sv
// Controller of the recoder: word loading, length scan and digit sequencing.
module mwr_ctrl
    import mwr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tlast,
    output logic        s_tready,
    input  mwr_status_t status,
    output mwr_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_LOAD);

    // Command decode and next state.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (s_tlast)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (status.word_nz || status.scan_bottom)
                begin
                    cmd.run_init = 1'b1;
                    state_next   = S_RUN;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_RUN:
            begin
                if (!status.more)
                begin
                    if (!status.out_busy)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_last = 1'b1;
                        state_next    = S_LOAD;
                    end
                end
                else if (status.group_full)
                begin
                    if (!status.out_busy)
                    begin
                        cmd.emit = 1'b1;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/modified_wnaf_recoder.sv
// Top level of the modified wNAF scalar recoder.
//
//  Channel     Direction  Contents
//  s_*         in         scalar_word in tdata, last_word in tlast
//  m_*         out        eight digits and digit_count in tdata, last_group in tlast
//  window_*    in         write of window_width, taken on every enabled edge
//
// After the last word a length scan walks the store from the top word down, one
// word a cycle. The recoding then produces one digit a cycle, up to 257 digits,
// plus an emit step per group of eight; a full output register holds the
// sequencer until the result transfers. Words are accepted again once the final
// group is emitted.
// Reset clears the scalar store and sets the window width to four.
module modified_wnaf_recoder
    import mwr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  window_width_wr_en,
    input  logic [WW_W-1:0]       window_width_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_IN_W-1:0]  s_tdata,   // [31:0] scalar_word
    input  logic                  s_tlast,   // last_word
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_OUT_W-1:0] m_tdata,   // digit_0..digit_7 [63:0], digit_count [67:64]
    output logic                  m_tlast    // last_group
);

    mwr_cmd_t    cmd;
    mwr_status_t status;

    mwr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mwr_datapath u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .window_width_wr_en   (window_width_wr_en),
        .window_width_wr_data (window_width_wr_data),
        .s_tdata              (s_tdata),
        .cmd                  (cmd),
        .status               (status),
        .m_tvalid             (m_tvalid),
        .m_tready             (m_tready),
        .m_tdata              (m_tdata),
        .m_tlast              (m_tlast)
    );

endmodule

FILE: tb/mwr_checker.sv
// Checker for the modified wNAF recoder: it predicts every digit group and compares.
module mwr_checker
    import mwr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  window_width_wr_en,
    input  logic [WW_W-1:0]       window_width_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [DATA_IN_W-1:0]  s_tdata,   // [31:0] scalar_word
    input  logic                  s_tlast,   // last_word
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [DATA_OUT_W-1:0] m_tdata,   // digit_0..digit_7 [63:0], digit_count [67:64]
    input  logic                  m_tlast,   // last_group
    output int                    fail_count,
    output int                    pending,
    output int                    groups_seen
);

    // One output group as the block should present it.
    typedef struct packed {
        logic [DIGIT_SLOTS-1:0][DIGIT_W-1:0] digits;
        logic [CNT_W-1:0]                    count;
        logic                                last;
    } digit_group_t;

    digit_group_t          expected_groups [$];
    logic [TOTAL_BITS-1:0] scalar_bits;
    int                    words_loaded;
    logic [WW_W-1:0]       window_width;

    // Recode a whole scalar into signed digits and queue the groups they form.
    function automatic void predict_groups(input logic [TOTAL_BITS-1:0] bits,
                                           input logic [WW_W-1:0] ww);
        int w;
        int top;
        int span;
        int half_mask;
        int len;
        int j;
        int win;
        int dig;
        int pos;
        int cnt;
        int digits [MAX_DIGITS];
        digit_group_t grp;
        w = (ww == '0) ? 1 : int'(ww);
        top = 1 << w;
        span = top << 1;
        half_mask = top - 1;
        len = 0;
        for (int n = 0; n < TOTAL_BITS; n++)
        begin
            if (bits[n])
                len = n + 1;
        end
        // The first window covers bits 0 to w.
        win = 0;
        for (int k = 0; k <= w; k++)
            win = win | (int'(bits[k]) << k);
        j = 0;
        while ((win != 0 || j + w + 1 < len) && j < MAX_DIGITS)
        begin
            dig = 0;
            if ((win & 1) != 0)
            begin
                // A high window gives a negative digit unless nothing lies above it.
                if ((win & top) != 0)
                begin
                    if (j + w + 1 >= len)
                        dig = win & half_mask;
                    else
                        dig = win - span;
                end
                else
                begin
                    dig = win;
                end
                win = win - dig;
            end
            digits[j] = dig;
            j++;
            win = win >> 1;
            if (j + w < TOTAL_BITS)
                win = win + top * int'(bits[j + w]);
            win = win & 'h1FF;
        end
        // Cut the digit string into groups; a zero scalar still gives one empty group.
        pos = 0;
        do
        begin
            cnt = j - pos;
            if (cnt > DIGITS_PER_RESULT)
                cnt = DIGITS_PER_RESULT;
            grp = '0;
            for (int slot = 0; slot < DIGIT_SLOTS; slot++)
            begin
                if (slot < cnt)
                    grp.digits[slot] = DIGIT_W'(digits[pos + slot]);
            end
            pos += cnt;
            grp.count = CNT_W'(cnt);
            grp.last = (pos >= j);
            expected_groups.push_back(grp);
        end
        while (pos < j);
    endfunction

    // Follow configuration writes and word transfers, and check every group transfer.
    always @(posedge clk or negedge rst_n)
    begin
        digit_group_t exp_grp;
        logic [DIGIT_W-1:0] act_digit;
        logic [CNT_W-1:0] act_count;
        if (!rst_n)
        begin
            expected_groups.delete();
            scalar_bits = '0;
            words_loaded = 0;
            window_width = WW_RESET;
            pending = 0;
        end
        else
        begin
            if (window_width_wr_en)
                window_width = window_width_wr_data;
            if (m_tvalid && m_tready)
            begin
                groups_seen++;
                if (expected_groups.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected group: expected none, got data %h last %b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    exp_grp = expected_groups.pop_front();
                    for (int i = 0; i < DIGIT_SLOTS; i++)
                    begin
                        act_digit = m_tdata[i*DIGIT_W +: DIGIT_W];
                        if (act_digit !== exp_grp.digits[i])
                        begin
                            fail_count++;
                            $display("%0t: digit_%0d expected %0d, got %0d", $time, i,
                                     $signed(exp_grp.digits[i]), $signed(act_digit));
                        end
                    end
                    act_count = m_tdata[DIGIT_SLOTS*DIGIT_W +: CNT_W];
                    if (act_count !== exp_grp.count)
                    begin
                        fail_count++;
                        $display("%0t: digit_count expected %0d, got %0d", $time,
                                 exp_grp.count, act_count);
                    end
                    if (m_tlast !== exp_grp.last)
                    begin
                        fail_count++;
                        $display("%0t: last_group expected %b, got %b", $time,
                                 exp_grp.last, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                // Words past the store size are dropped, but a closing one still counts.
                if (words_loaded < WORD_COUNT)
                begin
                    scalar_bits[words_loaded*WORD_BITS +: WORD_BITS] = s_tdata[WORD_BITS-1:0];
                    words_loaded++;
                end
                if (s_tlast)
                begin
                    predict_groups(scalar_bits, window_width);
                    scalar_bits = '0;
                    words_loaded = 0;
                end
            end
            pending = expected_groups.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
// Top of the recoder testbench: clock, reset, stimulus, receiver and the verdict.
module tb_top
    import mwr_pkg::*;
();

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  window_width_wr_en = 1'b0;
    logic [WW_W-1:0]       window_width_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_IN_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_OUT_W-1:0] m_tdata;
    logic                  m_tlast;

    int fail_count;
    int pending;
    int groups_seen;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_armed = 1'b0;
    int words_sent = 0;
    int scalars_sent = 0;

    modified_wnaf_recoder i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .window_width_wr_en   (window_width_wr_en),
        .window_width_wr_data (window_width_wr_data),
        .s_tvalid             (s_tvalid),
        .s_tready             (s_tready),
        .s_tdata              (s_tdata),
        .s_tlast              (s_tlast),
        .m_tvalid             (m_tvalid),
        .m_tready             (m_tready),
        .m_tdata              (m_tdata),
        .m_tlast              (m_tlast)
    );

    mwr_checker i_checker (
        .clk                  (clk),
        .rst_n                (rst_n),
        .window_width_wr_en   (window_width_wr_en),
        .window_width_wr_data (window_width_wr_data),
        .s_tvalid             (s_tvalid),
        .s_tready             (s_tready),
        .s_tdata              (s_tdata),
        .s_tlast              (s_tlast),
        .m_tvalid             (m_tvalid),
        .m_tready             (m_tready),
        .m_tdata              (m_tdata),
        .m_tlast              (m_tlast),
        .fail_count           (fail_count),
        .pending              (pending),
        .groups_seen          (groups_seen)
    );

    // Free-running clock with a period of 8.
    always #4 clk = ~clk;

    // Watchdog for a hung run.
    initial
    begin
        #8000000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off during the pressure phase.
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_armed && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one word and hold it until it transfers; entered and left at a falling edge.
    task automatic push_word(input logic [WORD_BITS-1:0] word, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        words_sent++;
        if (last)
            scalars_sent++;
    endtask

    // Stop sending and let every expected group arrive before the block is touched.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Write the window width while the block is idle.
    task automatic write_width(input logic [WW_W-1:0] value);
        window_width_wr_en <= 1'b1;
        window_width_wr_data <= value;
        @(negedge clk);
        window_width_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Word contents that mix dense, empty, full and sparse patterns.
    function automatic logic [WORD_BITS-1:0] random_word();
        case ($urandom_range(5))
            0: return WORD_BITS'($urandom);
            1: return '0;
            2: return '1;
            3: return WORD_BITS'(1) << $urandom_range(WORD_BITS - 1);
            4: return WORD_BITS'($urandom_range(255));
            default: return ~(WORD_BITS'(1) << $urandom_range(WORD_BITS - 1));
        endcase
    endfunction

    // One window setting with a traffic pattern, ended by a full drain.
    task automatic run_phase(input logic [WW_W-1:0] ww, input int sidle, input int rstall,
                             input int words);
        int sent;
        int n;
        write_width(ww);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        sent = 0;
        while (sent < words)
        begin
            // Mostly proper scalars of one to eight words, sometimes overlong ones.
            if ($urandom_range(99) < 85)
                n = $urandom_range(1, WORD_COUNT);
            else
                n = $urandom_range(WORD_COUNT + 1, WORD_COUNT + 3);
            for (int i = 0; i < n; i++)
                push_word(random_word(), i == n - 1);
            sent += n;
        end
        drain();
    endtask

    // Main sequence.
    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed scalars at the reset width: zero, one, all ones, overlong, one word.
        push_word('0, 1'b1);
        push_word(WORD_BITS'(1), 1'b1);
        for (int i = 0; i < WORD_COUNT; i++)
            push_word('1, i == WORD_COUNT - 1);
        for (int i = 0; i < WORD_COUNT + 2; i++)
            push_word(32'hA5A5_5A5A ^ WORD_BITS'(i), i == WORD_COUNT + 1);
        push_word('1, 1'b1);
        drain();

        // A zero width behaves as width one.
        write_width('0);
        push_word(32'hDEAD_BEEF, 1'b0);
        push_word(32'h0000_0001, 1'b1);
        drain();

        // Widest window.
        write_width(3'd7);
        push_word(32'h8000_0000, 1'b1);
        push_word(32'h0000_007F, 1'b1);
        drain();

        // Random phases over the widths and idling patterns.
        run_phase(3'd1, 0, 0, 75);
        run_phase(3'd7, 83, 0, 75);
        run_phase(3'd3, 0, 83, 75);
        run_phase(3'd5, 20, 20, 75);
        hold_armed = 1'b1;
        run_phase(3'd2, 0, 0, 40);
        run_phase(3'd6, 20, 20, 75);
        run_phase('0, 0, 0, 30);

        $display("Sent %0d words in %0d scalars at window widths 0 to 7, %0d groups checked.",
                 words_sent, scalars_sent, groups_seen);
        $display("Phases covered free flow, sender gaps, receiver stalls and a long hold-off.");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/mwr_pkg.sv
hw/rtl/mwr_datapath.sv
hw/rtl/mwr_ctrl.sv
hw/rtl/modified_wnaf_recoder.sv
tb/mwr_checker.sv
tb/tb_top.sv
